[rtl/idq_pkg.sv]
// ----------------------------------------------------------------------------
// idq_pkg
// Shared constants, types and helpers for the dotted-quad address checker.
// ----------------------------------------------------------------------------
package idq_pkg;

    localparam int MAX_CHARS   = 15;
    localparam int FIELD_COUNT = 4;

    // counters saturate one past their limit
    localparam int CC_W = $clog2(MAX_CHARS + 2);
    localparam int FC_W = $clog2(FIELD_COUNT + 2);

    // field value saturates at 256
    localparam int FV_W      = 9;
    localparam int FIELD_MAX = 255;
    localparam int FIELD_SAT = 256;
    localparam int PROD_W    = 12;

    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    typedef enum logic [3:0] {
        ERR_OK          = 4'd0,
        ERR_EMPTY       = 4'd1,
        ERR_TOO_LONG    = 4'd2,
        ERR_TRAIL_DOT   = 4'd3,
        ERR_EMPTY_FIELD = 4'd4,
        ERR_SPACE       = 4'd5,
        ERR_NONDIGIT    = 4'd6,
        ERR_OVER        = 4'd7,
        ERR_COUNT       = 4'd8
    } err_code_t;

    typedef struct packed {
        logic       is_dot;
        logic       is_space;
        logic       is_digit;
        logic [3:0] digit;
    } char_class_t;

    typedef struct packed {
        char_class_t cls;
        logic        last;
        logic        none;
    } item_t;

    // judge one closed field; ERR_OK means the field is good
    function automatic err_code_t field_err(
        input logic            has_char,
        input logic            has_space,
        input logic            has_other,
        input logic [FV_W-1:0] value
    );
        err_code_t e;
        if (!has_char) begin
            e = ERR_EMPTY_FIELD;
        end else if (has_space) begin
            e = ERR_SPACE;
        end else if (has_other) begin
            e = ERR_NONDIGIT;
        end else if (value > FV_W'(FIELD_MAX)) begin
            e = ERR_OVER;
        end else begin
            e = ERR_OK;
        end
        return e;
    endfunction

endpackage

[rtl/idq_classify.sv]
// ----------------------------------------------------------------------------
// idq_classify
// Decodes one character byte into dot, space and digit classes.
// ----------------------------------------------------------------------------
module idq_classify (
    input  logic [7:0]           char_code,
    output idq_pkg::char_class_t cls
);

    logic [7:0] offset;

    assign offset       = char_code - idq_pkg::CHAR_ZERO;
    assign cls.is_dot   = (char_code == idq_pkg::CHAR_DOT);
    assign cls.is_space = (char_code == idq_pkg::CHAR_SPACE);
    assign cls.is_digit = (char_code >= idq_pkg::CHAR_ZERO) &&
                          (char_code <= idq_pkg::CHAR_NINE);
    assign cls.digit    = offset[3:0];

endmodule

[rtl/idq_track.sv]
// ----------------------------------------------------------------------------
// idq_track
// Per-string tracking state: character count, open field and verdict.
// ----------------------------------------------------------------------------
module idq_track (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               fire,
    input  idq_pkg::item_t     item,
    output idq_pkg::err_code_t verdict
);

    logic [idq_pkg::CC_W-1:0] char_count_reg, char_count_next;
    logic [idq_pkg::FV_W-1:0] field_value_reg, field_value_next;
    logic                     has_char_reg, has_char_next;
    logic                     has_space_reg, has_space_next;
    logic                     has_other_reg, has_other_next;
    logic [idq_pkg::FC_W-1:0] field_count_reg, field_count_next;
    idq_pkg::err_code_t       first_err_reg, first_err_next;
    logic                     prev_dot_reg, prev_dot_next;

    always_comb begin
        logic [idq_pkg::CC_W-1:0]   cc;
        logic [idq_pkg::FV_W-1:0]   val;
        logic                       hc, hs, ho, pd;
        logic [idq_pkg::FC_W-1:0]   fc, fc_end;
        idq_pkg::err_code_t         fe, ferr, fe_end;
        logic [idq_pkg::PROD_W-1:0] prod;

        cc  = char_count_reg;
        val = field_value_reg;
        hc  = has_char_reg;
        hs  = has_space_reg;
        ho  = has_other_reg;
        fc  = field_count_reg;
        fe  = first_err_reg;
        pd  = prev_dot_reg;
        prod = idq_pkg::PROD_W'(field_value_reg) * idq_pkg::PROD_W'(10)
             + idq_pkg::PROD_W'(item.cls.digit);

        if (!item.none) begin
            if (cc < idq_pkg::CC_W'(idq_pkg::MAX_CHARS + 1)) begin
                cc = cc + idq_pkg::CC_W'(1);
            end
            if (item.cls.is_dot) begin
                // close the open field
                pd   = 1'b1;
                ferr = idq_pkg::field_err(hc, hs, ho, val);
                if (fe == idq_pkg::ERR_OK) begin
                    fe = ferr;
                end
                if (fc < idq_pkg::FC_W'(idq_pkg::FIELD_COUNT + 1)) begin
                    fc = fc + idq_pkg::FC_W'(1);
                end
                val = '0;
                hc  = 1'b0;
                hs  = 1'b0;
                ho  = 1'b0;
            end else begin
                pd = 1'b0;
                hc = 1'b1;
                if (item.cls.is_space) begin
                    hs = 1'b1;
                end else if (item.cls.is_digit) begin
                    val = (prod > idq_pkg::PROD_W'(idq_pkg::FIELD_SAT))
                        ? idq_pkg::FV_W'(idq_pkg::FIELD_SAT) : prod[idq_pkg::FV_W-1:0];
                end else begin
                    ho = 1'b1;
                end
            end
        end

        // final field closes at end of string
        ferr   = idq_pkg::field_err(hc, hs, ho, val);
        fe_end = (fe == idq_pkg::ERR_OK) ? ferr : fe;
        fc_end = (fc < idq_pkg::FC_W'(idq_pkg::FIELD_COUNT + 1))
               ? fc + idq_pkg::FC_W'(1) : fc;

        priority if (cc == '0) begin
            verdict = idq_pkg::ERR_EMPTY;
        end else if (cc > idq_pkg::CC_W'(idq_pkg::MAX_CHARS)) begin
            verdict = idq_pkg::ERR_TOO_LONG;
        end else if (pd) begin
            verdict = idq_pkg::ERR_TRAIL_DOT;
        end else if (fe_end != idq_pkg::ERR_OK) begin
            verdict = fe_end;
        end else if (fc_end != idq_pkg::FC_W'(idq_pkg::FIELD_COUNT)) begin
            verdict = idq_pkg::ERR_COUNT;
        end else begin
            verdict = idq_pkg::ERR_OK;
        end

        char_count_next  = char_count_reg;
        field_value_next = field_value_reg;
        has_char_next    = has_char_reg;
        has_space_next   = has_space_reg;
        has_other_next   = has_other_reg;
        field_count_next = field_count_reg;
        first_err_next   = first_err_reg;
        prev_dot_next    = prev_dot_reg;
        if (fire) begin
            if (item.last) begin
                // verdict given: start a fresh string
                char_count_next  = '0;
                field_value_next = '0;
                has_char_next    = 1'b0;
                has_space_next   = 1'b0;
                has_other_next   = 1'b0;
                field_count_next = '0;
                first_err_next   = idq_pkg::ERR_OK;
                prev_dot_next    = 1'b0;
            end else begin
                char_count_next  = cc;
                field_value_next = val;
                has_char_next    = hc;
                has_space_next   = hs;
                has_other_next   = ho;
                field_count_next = fc;
                first_err_next   = fe;
                prev_dot_next    = pd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            char_count_reg  <= '0;
            field_value_reg <= '0;
            has_char_reg    <= 1'b0;
            has_space_reg   <= 1'b0;
            has_other_reg   <= 1'b0;
            field_count_reg <= '0;
            first_err_reg   <= idq_pkg::ERR_OK;
            prev_dot_reg    <= 1'b0;
        end else begin
            char_count_reg  <= char_count_next;
            field_value_reg <= field_value_next;
            has_char_reg    <= has_char_next;
            has_space_reg   <= has_space_next;
            has_other_reg   <= has_other_next;
            field_count_reg <= field_count_next;
            first_err_reg   <= first_err_next;
            prev_dot_reg    <= prev_dot_next;
        end
    end

endmodule

[rtl/ipv4_dotted_quad_checker.sv]
// ----------------------------------------------------------------------------
// ipv4_dotted_quad_checker
// Checks an IPv4 dotted-decimal address streamed one character per transfer.
// ----------------------------------------------------------------------------
//  channel | dir | tdata              | tuser        | tlast
//  s_      | in  | [7:0] char_code    | [0] no_char  | is_last
//  m_      | out | [3:0] error_code   | [0] is_valid | -
//
//  One character per cycle while no last transfer is stalled. A character
//  waits in the input register; its state update and, on the last transfer,
//  the verdict are computed there and are registered as the character fires.
//  A pending verdict stalls a following last transfer and the input behind
//  it; earlier characters keep flowing. Synchronous active-low reset clears
//  all string state.
// ----------------------------------------------------------------------------
module ipv4_dotted_quad_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_code
    input  logic       s_tlast,
    input  logic [0:0] s_tuser,   // [0] no_char
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [3:0] error_code, [7:4] zero
    output logic [0:0] m_tuser    // [0] is_valid
);

    logic               in_valid_reg, in_valid_next;
    logic [7:0]         in_char_reg;
    logic               in_last_reg;
    logic               in_none_reg;
    logic               out_valid_reg, out_valid_next;
    idq_pkg::err_code_t out_err_reg;
    logic               fire;
    logic               s_fire;
    idq_pkg::char_class_t cls;
    idq_pkg::item_t     item;
    idq_pkg::err_code_t verdict;

    idq_classify u_classify (
        .char_code (in_char_reg),
        .cls       (cls)
    );

    assign item.cls  = cls;
    assign item.last = in_last_reg;
    assign item.none = in_none_reg;

    idq_track u_track (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item),
        .verdict (verdict)
    );

    // advance unless a verdict would overwrite one still waiting
    assign fire     = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (fire) begin
            in_valid_next = 1'b0;
        end
        if (s_fire) begin
            in_valid_next = 1'b1;
        end
        if (m_tvalid && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (fire && in_last_reg) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
            in_none_reg <= s_tuser[0];
        end
        if (fire && in_last_reg) begin
            out_err_reg <= verdict;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {4'b0000, out_err_reg};
    assign m_tuser[0] = (out_err_reg == idq_pkg::ERR_OK);

    // a verdict is always one of the defined codes
    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[3:0] <= idq_pkg::ERR_COUNT))
        else $error("verdict code out of range");

    // a fired last character always yields a pending result
    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && in_last_reg) |=> m_tvalid)
        else $error("last transfer produced no verdict");

    // a waiting verdict is never overwritten while stalled
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !(fire && in_last_reg))
        else $error("pending verdict overwritten");

    // input register empties only by firing
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !fire) |=> in_valid_reg)
        else $error("held character dropped");

endmodule
